@@ rtl/core/gpr_pkg.sv @@
// Shared types and constants for the grid path reachability block.
// Used by the classifier, the item queue and the flood engine; no dependencies.
package gpr_pkg;

  // Coordinate fields are four bits wide at the ports
  localparam int COORD_W = 4;

  // Work classes decided at the front
  typedef enum logic [3:0] {
    OP_WRITE  = 4'b0001,  // set or clear one in-range cell
    OP_SEARCH = 4'b0010,  // flood from start toward target
    OP_HIT    = 4'b0100,  // answer is known to be 1 (start equals target)
    OP_MISS   = 4'b1000   // answer is known to be 0 (coordinate off the grid)
  } op_t;

  // One classified item as it travels through the queue
  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               occupied;
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
  } item_t;

endpackage

@@ rtl/core/gpr_front.sv @@
// Front end: classifies each incoming item and drops writes that fall off the grid.
// Depends on gpr_pkg for the item and class types.
module gpr_front import gpr_pkg::*; #(
  parameter int GRID_SIDE = 9
) (
  input  logic               kind,
  input  logic [COORD_W-1:0] cell_x,
  input  logic [COORD_W-1:0] cell_y,
  input  logic               occupied,
  input  logic [COORD_W-1:0] target_x,
  input  logic [COORD_W-1:0] target_y,
  output item_t              item,
  output logic               keep
);

  localparam logic [COORD_W:0] SIDE = (COORD_W+1)'(GRID_SIDE);

  logic start_in;
  logic target_in;
  logic same_cell;

  // Range checks on one extra bit so a side of sixteen still compares right
  assign start_in  = ({1'b0, cell_x} < SIDE) && ({1'b0, cell_y} < SIDE);
  assign target_in = ({1'b0, target_x} < SIDE) && ({1'b0, target_y} < SIDE);
  assign same_cell = (cell_x == target_x) && (cell_y == target_y);

  // Pick the work class; an off-grid query still answers 0 even on the same cell
  always_comb begin
    item.x        = cell_x;
    item.y        = cell_y;
    item.occupied = occupied;
    item.tx       = target_x;
    item.ty       = target_y;
    keep          = 1'b1;
    priority if (!kind) begin
      item.op = OP_WRITE;
      keep    = start_in;
    end else if (!(start_in && target_in)) begin
      item.op = OP_MISS;
    end else if (same_cell) begin
      item.op = OP_HIT;
    end else begin
      item.op = OP_SEARCH;
    end
  end

endmodule

@@ rtl/core/gpr_queue.sv @@
// Short FIFO of classified items between the front end and the flood engine.
// Depends on gpr_pkg for the item type.
module gpr_queue import gpr_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && nonempty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && nonempty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/gpr_back.sv @@
// Back end: holds the occupancy grid and runs the wavefront flood for each query.
// Depends on gpr_pkg for the item and class types.
module gpr_back import gpr_pkg::*; #(
  parameter int GRID_SIDE = 9
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  result_valid,
  input  logic  result_ready,
  output logic  reachable
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLOOD = 2'b10
  } state_t;

  state_t             state;
  logic [CELLS-1:0]   occ;
  logic [CELLS-1:0]   visited;
  logic [CELLS-1:0]   grow;
  logic [CELLS-1:0]   start_hot;
  logic [CELLS-1:0]   write_hot;
  logic [CELLS-1:0]   target_hot;
  logic [COORD_W-1:0] tx;
  logic [COORD_W-1:0] ty;
  logic               slot_free;
  logic               hit;
  logic               done;
  logic               out_load;
  logic               out_value;

  // One cell per grid position: decodes and the one-ring spread of the wavefront
  for (genvar gy = 0; gy < GRID_SIDE; gy++) begin : g_row
    for (genvar gx = 0; gx < GRID_SIDE; gx++) begin : g_col
      localparam int I = gy * GRID_SIDE + gx;
      logic from_l, from_r, from_u, from_d;
      logic here;

      if (gx > 0) begin : g_l
        assign from_l = visited[I-1];
      end else begin : g_nl
        assign from_l = 1'b0;
      end
      if (gx < GRID_SIDE - 1) begin : g_r
        assign from_r = visited[I+1];
      end else begin : g_nr
        assign from_r = 1'b0;
      end
      if (gy > 0) begin : g_u
        assign from_u = visited[I-GRID_SIDE];
      end else begin : g_nu
        assign from_u = 1'b0;
      end
      if (gy < GRID_SIDE - 1) begin : g_d
        assign from_d = visited[I+GRID_SIDE];
      end else begin : g_nd
        assign from_d = 1'b0;
      end

      assign here = (q_item.x == COORD_W'(gx)) && (q_item.y == COORD_W'(gy));
      assign start_hot[I]  = here;
      assign write_hot[I]  = here;
      assign target_hot[I] = (tx == COORD_W'(gx)) && (ty == COORD_W'(gy));
      assign grow[I] = visited[I] | (~occ[I] & (from_l | from_r | from_u | from_d));
    end
  end

  assign slot_free = !result_valid || result_ready;
  assign hit       = |(grow & target_hot);
  assign done      = hit || (grow == visited);

  // Take the head item when its work can finish in this cycle or start a flood
  always_comb begin
    q_pop = 1'b0;
    if (state == ST_IDLE && q_valid) begin
      unique case (q_item.op)
        OP_WRITE, OP_SEARCH: q_pop = 1'b1;
        OP_HIT, OP_MISS:     q_pop = slot_free;
        default:             q_pop = 1'b0;
      endcase
    end
  end

  // Pick the result that completes in this cycle, if any
  always_comb begin
    out_load  = 1'b0;
    out_value = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_pop && (q_item.op == OP_HIT || q_item.op == OP_MISS)) begin
          out_load  = 1'b1;
          out_value = (q_item.op == OP_HIT);
        end
      end
      ST_FLOOD: begin
        out_load  = done && slot_free;
        out_value = hit;
      end
      default: ;
    endcase
  end

  // Apply writes to the occupancy grid
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (q_pop && q_item.op == OP_WRITE) begin
      occ <= (occ & ~write_hot) | (write_hot & {CELLS{q_item.occupied}});
    end
  end

  // Load the output register, or drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
      reachable    <= out_value;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Sequence the flood
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_pop && q_item.op == OP_SEARCH) begin
            visited <= start_hot;
            tx      <= q_item.tx;
            ty      <= q_item.ty;
            state   <= ST_FLOOD;
          end
        end
        ST_FLOOD: begin
          if (done) begin
            // hold the finished map until the output slot frees up
            if (slot_free) begin
              state <= ST_IDLE;
            end
          end else begin
            visited <= grow;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The wavefront only ever grows while one query floods
  a_flood_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLOOD && $past(state == ST_FLOOD) && !$past(rst))
      |-> ((visited & $past(visited)) == $past(visited)))
    else $error("visited map lost a cell during a flood");

  // A flood always carries at least its start cell
  a_flood_seeded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLOOD) |-> (visited != '0))
    else $error("flood running with an empty visited map");

  // A new result comes only from a finished flood or a pre-decided query
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    ($rose(result_valid) && !$past(rst))
      |-> $past(state == ST_FLOOD || (state == ST_IDLE && q_valid)))
    else $error("result raised without a query behind it");

endmodule

@@ rtl/core/grid_path_reachability.sv @@
// Top level of the grid path reachability block.
// Depends on gpr_pkg, gpr_front, gpr_queue and gpr_back.
//
// Keeps a GRID_SIDE x GRID_SIDE occupancy map and answers four-way reachability
// queries. Items pass through a classifier and a QUEUE_DEPTH-entry queue into
// the flood engine, so the input side keeps taking items while a flood runs
// or a result waits, until the queue is full. A write, or a query decided up
// front (start equal to target, or a coordinate off the grid), needs no flood.
// A flood query seeds the visited map with its start cell, then spreads the
// wavefront by one ring at each step, until the target is met or the wave
// stops growing. Writes out of the grid are dropped at the input and give
// no result.
module grid_path_reachability import gpr_pkg::*; #(
  parameter int GRID_SIDE   = 9,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               kind,
  input  logic [COORD_W-1:0] cell_x,
  input  logic [COORD_W-1:0] cell_y,
  input  logic               occupied,
  input  logic [COORD_W-1:0] target_x,
  input  logic [COORD_W-1:0] target_y,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               reachable
);

  item_t cls_item;
  item_t head;
  logic  keep;
  logic  full;
  logic  nonempty;
  logic  pop;

  assign item_ready = !full;

  // Classify incoming items
  gpr_front #(
    .GRID_SIDE (GRID_SIDE)
  ) u_front (
    .kind     (kind),
    .cell_x   (cell_x),
    .cell_y   (cell_y),
    .occupied (occupied),
    .target_x (target_x),
    .target_y (target_y),
    .item     (cls_item),
    .keep     (keep)
  );

  // Decouple the front from the flood engine
  gpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid && keep),
    .push_item (cls_item),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head)
  );

  // Run writes and floods
  gpr_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (nonempty),
    .q_item       (head),
    .q_pop        (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .reachable    (reachable)
  );

endmodule
